@@ rtl/rtdd_pkg.sv @@
// ----------------------------------------------------------------------------
// rtdd_pkg
// Shared constants, codes and width helpers for the two-axis rotor drive.
// ----------------------------------------------------------------------------
package rtdd_pkg;

  localparam int ADC_BITS_DEFAULT = 10;

  // scaling to hundredths of a degree: sample * SCALE_NUM / divisor
  localparam int SCALE_NUM = 10000;
  localparam int AZ_DIV    = 227;
  localparam int EL_DIV    = 568;

  // guard bits of the reciprocal; 2**RECIP_GUARD must exceed EL_DIV and AZ_DIV
  localparam int RECIP_GUARD = 10;

  localparam int TARGET_W   = 16;
  localparam int DEADBAND_W = 16;
  localparam int OFFSET_W   = 14;
  localparam int AZ_POS_W   = 17;
  localparam int EL_POS_W   = 15;
  localparam int U16_MAX    = 65535;

  localparam logic [TARGET_W-1:0]   MAX_AZ_REQ     = 16'd45000;
  localparam logic [TARGET_W-1:0]   MAX_EL_REQ     = 16'd18000;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 16'd100;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1
  } cmd_t;

  typedef enum logic {
    REG_DEADBAND  = 1'b0,
    REG_AZ_OFFSET = 1'b1
  } reg_idx_t;

  // bits needed for the largest scaled azimuth before the offset:
  // smallest w with max_sample * SCALE_NUM < AZ_DIV * 2^w
  function automatic int az_q_width(int adc_bits);
    longint m;
    int     w;
    m = ((longint'(1) << adc_bits) - 1) * longint'(SCALE_NUM);
    w = 0;
    while ((longint'(AZ_DIV) << w) <= m) w++;
    return w;
  endfunction

  // bits needed for the largest scaled elevation
  function automatic int el_q_width(int adc_bits);
    longint m;
    int     w;
    m = ((longint'(1) << adc_bits) - 1) * longint'(SCALE_NUM);
    w = 0;
    while ((longint'(EL_DIV) << w) <= m) w++;
    return w;
  endfunction

endpackage

@@ rtl/rtdd_if.sv @@
// ----------------------------------------------------------------------------
// rtdd_if
// Valid/ready channels of the rotor drive: request items and result items.
// ----------------------------------------------------------------------------
interface rtdd_req_if import rtdd_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEFAULT
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic [ADC_BITS-1:0]   azimuth_sample;
  logic [ADC_BITS-1:0]   elevation_sample;
  logic [TARGET_W-1:0]   azimuth_request;
  logic [TARGET_W-1:0]   elevation_request;

  modport source (
    output valid, cmd, azimuth_sample, elevation_sample, azimuth_request,
           elevation_request,
    input  ready
  );
  modport sink (
    input  valid, cmd, azimuth_sample, elevation_sample, azimuth_request,
           elevation_request,
    output ready
  );
endinterface

interface rtdd_rsp_if import rtdd_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        turn_right;
  logic                        turn_left;
  logic                        tilt_up;
  logic                        tilt_down;
  logic signed [AZ_POS_W-1:0]  azimuth_position;
  logic [EL_POS_W-1:0]         elevation_position;
  logic                        command_accepted;

  modport source (
    output valid, turn_right, turn_left, tilt_up, tilt_down, azimuth_position,
           elevation_position, command_accepted,
    input  ready
  );
  modport sink (
    input  valid, turn_right, turn_left, tilt_up, tilt_down, azimuth_position,
           elevation_position, command_accepted,
    output ready
  );
endinterface

@@ rtl/two_axis_rotor_deadband_drive.sv @@
// ----------------------------------------------------------------------------
// two_axis_rotor_deadband_drive
// Two-axis antenna rotor bang-bang drive with a deadband around the target.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per item: a tick with both converter samples,
//   a target write, or another command that only repeats the outputs.
//   rsp returns exactly one result per request transaction, in order.
//   The APB port holds the deadband (byte address 0) and the azimuth zero
//   offset (byte address 4); write them only while no transaction is in flight.
// Timing:
//   Three register stages: input, scaled position, result; a request passes
//   the first two before its result is valid. One transaction is taken every
//   cycle while rsp.ready is high; the scaling multipliers sit in the second
//   stage and the target update and deadband compare in the third.
// Reset:
//   Targets are unset (the first tick seeds them from the measured position),
//   all drives stop, positions read zero, deadband is 100, offset is 0.
// Stall:
//   While rsp.ready is low the result holds; the two earlier stages keep
//   filling, and req.ready drops once all three stages hold a transaction.
// ----------------------------------------------------------------------------
module two_axis_rotor_deadband_drive import rtdd_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  rtdd_req_if.sink               req,
  rtdd_rsp_if.source             rsp,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int AZ_QW = az_q_width(ADC_BITS);
  localparam int EL_QW = el_q_width(ADC_BITS);

  logic                        sc_valid;
  logic                        sc_ready;
  logic [1:0]                  sc_cmd;
  logic [AZ_QW-1:0]            sc_az_q;
  logic [EL_QW-1:0]            sc_el_q;
  logic [TARGET_W-1:0]         sc_az_req;
  logic [TARGET_W-1:0]         sc_el_req;
  logic [DEADBAND_W-1:0]       deadband;
  logic signed [OFFSET_W-1:0]  azimuth_zero_offset;

  rtdd_regs u_regs (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .deadband            (deadband),
    .azimuth_zero_offset (azimuth_zero_offset)
  );

  rtdd_scale #(
    .ADC_BITS (ADC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .sc_valid  (sc_valid),
    .sc_ready  (sc_ready),
    .sc_cmd    (sc_cmd),
    .sc_az_q   (sc_az_q),
    .sc_el_q   (sc_el_q),
    .sc_az_req (sc_az_req),
    .sc_el_req (sc_el_req)
  );

  rtdd_track #(
    .ADC_BITS (ADC_BITS)
  ) u_track (
    .clk                 (clk),
    .rst                 (rst),
    .sc_valid            (sc_valid),
    .sc_ready            (sc_ready),
    .sc_cmd              (sc_cmd),
    .sc_az_q             (sc_az_q),
    .sc_el_q             (sc_el_q),
    .sc_az_req           (sc_az_req),
    .sc_el_req           (sc_el_req),
    .deadband            (deadband),
    .azimuth_zero_offset (azimuth_zero_offset),
    .rsp                 (rsp)
  );

endmodule

@@ rtl/rtdd_regs.sv @@
// ----------------------------------------------------------------------------
// rtdd_regs
// APB register file: deadband and azimuth zero offset.
// ----------------------------------------------------------------------------
module rtdd_regs import rtdd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_ADDR_W-1:0]       paddr,
  input  logic [APB_DATA_W-1:0]       pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready,
  output logic [DEADBAND_W-1:0]       deadband,
  output logic signed [OFFSET_W-1:0]  azimuth_zero_offset
);

  reg_idx_t sel;
  logic     wr;

  // word decode: byte lanes within a register are ignored
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband            <= DEADBAND_RESET;
      azimuth_zero_offset <= '0;
    end else if (wr) begin
      unique case (sel)
        REG_DEADBAND:  deadband            <= pwdata[DEADBAND_W-1:0];
        REG_AZ_OFFSET: azimuth_zero_offset <= pwdata[OFFSET_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_DEADBAND:  prdata = APB_DATA_W'(deadband);
      REG_AZ_OFFSET: prdata = APB_DATA_W'(azimuth_zero_offset);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/rtdd_scale.sv @@
// ----------------------------------------------------------------------------
// rtdd_scale
// Input register and scaling stage: converter counts to hundredths of a degree.
// ----------------------------------------------------------------------------
module rtdd_scale import rtdd_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEFAULT,
  localparam int AZ_QW = az_q_width(ADC_BITS),
  localparam int EL_QW = el_q_width(ADC_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  rtdd_req_if.sink             req,
  output logic                 sc_valid,
  input  logic                 sc_ready,
  output logic [1:0]           sc_cmd,
  output logic [AZ_QW-1:0]     sc_az_q,
  output logic [EL_QW-1:0]     sc_el_q,
  output logic [TARGET_W-1:0]  sc_az_req,
  output logic [TARGET_W-1:0]  sc_el_req
);

  // floor(s * 10000 / d) == (s * ceil(2^K * 10000 / d)) >> K for all s < 2^ADC_BITS
  localparam int K  = ADC_BITS + RECIP_GUARD;
  localparam int MW = K + 6;
  localparam int PW = ADC_BITS + MW;
  localparam longint AZ_MUL_L =
    ((longint'(1) << K) * longint'(SCALE_NUM) + longint'(AZ_DIV) - 1) / longint'(AZ_DIV);
  localparam longint EL_MUL_L =
    ((longint'(1) << K) * longint'(SCALE_NUM) + longint'(EL_DIV) - 1) / longint'(EL_DIV);
  localparam logic [MW-1:0] AZ_MUL = MW'(AZ_MUL_L);
  localparam logic [MW-1:0] EL_MUL = MW'(EL_MUL_L);

  logic                 in_valid;
  logic [1:0]           in_cmd;
  logic [ADC_BITS-1:0]  in_az_s;
  logic [ADC_BITS-1:0]  in_el_s;
  logic [TARGET_W-1:0]  in_az_req;
  logic [TARGET_W-1:0]  in_el_req;
  logic                 sc_free;
  logic [PW-1:0]        az_prod;
  logic [PW-1:0]        el_prod;

  assign sc_free   = !sc_valid || sc_ready;
  assign req.ready = !in_valid || sc_free;

  assign az_prod = PW'(in_az_s) * PW'(AZ_MUL);
  assign el_prod = PW'(in_el_s) * PW'(EL_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sc_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        in_valid <= req.valid;
      end
      if (sc_free) begin
        sc_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_cmd    <= req.cmd;
      in_az_s   <= req.azimuth_sample;
      in_el_s   <= req.elevation_sample;
      in_az_req <= req.azimuth_request;
      in_el_req <= req.elevation_request;
    end
    if (sc_free && in_valid) begin
      sc_cmd    <= in_cmd;
      sc_az_q   <= az_prod[K +: AZ_QW];
      sc_el_q   <= el_prod[K +: EL_QW];
      sc_az_req <= in_az_req;
      sc_el_req <= in_el_req;
    end
  end

endmodule

@@ rtl/rtdd_track.sv @@
// ----------------------------------------------------------------------------
// rtdd_track
// Target state, deadband compare and result register of the rotor drive.
// ----------------------------------------------------------------------------
module rtdd_track import rtdd_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEFAULT,
  localparam int AZ_QW = az_q_width(ADC_BITS),
  localparam int EL_QW = el_q_width(ADC_BITS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sc_valid,
  output logic                        sc_ready,
  input  logic [1:0]                  sc_cmd,
  input  logic [AZ_QW-1:0]            sc_az_q,
  input  logic [EL_QW-1:0]            sc_el_q,
  input  logic [TARGET_W-1:0]         sc_az_req,
  input  logic [TARGET_W-1:0]         sc_el_req,
  input  logic [DEADBAND_W-1:0]       deadband,
  input  logic signed [OFFSET_W-1:0]  azimuth_zero_offset,
  rtdd_rsp_if.source                  rsp
);

  // azimuth after offset: signed, wide enough to hold 65535 and the 17 bit report
  localparam int AZW   = ((AZ_QW + 1 > AZ_POS_W) ? AZ_QW + 1 : AZ_POS_W) + 1;
  localparam int EL_XW = (EL_QW > AZ_POS_W) ? EL_QW : AZ_POS_W;
  localparam int AZ_EW = AZW + 1;
  localparam int EL_EW = EL_XW + 1;

  logic [TARGET_W-1:0]       az_target, az_target_next;
  logic [TARGET_W-1:0]       el_target, el_target_next;
  logic                      target_set, target_set_next;
  logic                      right_next, left_next, up_next, down_next;
  logic [AZ_POS_W-1:0]       az_pos_next;
  logic [EL_POS_W-1:0]       el_pos_next;
  logic                      accepted_next;

  logic                      fire;
  logic signed [AZW-1:0]     az_pos;
  logic [EL_XW-1:0]          el_ext;
  logic [TARGET_W-1:0]       az_clamp, el_clamp;
  logic [TARGET_W-1:0]       az_tgt_eff, el_tgt_eff;
  logic signed [AZ_EW-1:0]   az_err, az_db;
  logic signed [EL_EW-1:0]   el_err, el_db;
  logic                      req_ok;

  assign sc_ready = !rsp.valid || rsp.ready;
  assign fire     = sc_valid && sc_ready;

  assign az_pos = $signed(AZW'(sc_az_q)) - AZW'(azimuth_zero_offset);
  assign el_ext = EL_XW'(sc_el_q);

  // seed value for an unset target: position clamped to 0..65535
  always_comb begin
    if (az_pos[AZW-1]) begin
      az_clamp = '0;
    end else if (az_pos > AZW'(U16_MAX)) begin
      az_clamp = '1;
    end else begin
      az_clamp = az_pos[TARGET_W-1:0];
    end
    el_clamp = (el_ext > EL_XW'(U16_MAX)) ? '1 : el_ext[TARGET_W-1:0];
  end

  assign az_tgt_eff = target_set ? az_target : az_clamp;
  assign el_tgt_eff = target_set ? el_target : el_clamp;

  assign az_err = $signed(AZ_EW'(az_tgt_eff)) - AZ_EW'(az_pos);
  assign el_err = $signed(EL_EW'(el_tgt_eff)) - $signed(EL_EW'(el_ext));
  assign az_db  = $signed(AZ_EW'(deadband));
  assign el_db  = $signed(EL_EW'(deadband));

  assign req_ok = (sc_az_req <= MAX_AZ_REQ) && (sc_el_req <= MAX_EL_REQ);

  always_comb begin
    az_target_next  = az_target;
    el_target_next  = el_target;
    target_set_next = target_set;
    right_next      = rsp.turn_right;
    left_next       = rsp.turn_left;
    up_next         = rsp.tilt_up;
    down_next       = rsp.tilt_down;
    az_pos_next     = rsp.azimuth_position;
    el_pos_next     = rsp.elevation_position;
    accepted_next   = 1'b0;
    unique case (sc_cmd)
      CMD_TICK: begin
        az_target_next  = az_tgt_eff;
        el_target_next  = el_tgt_eff;
        target_set_next = 1'b1;
        right_next      = az_err > az_db;
        left_next       = az_err < -az_db;
        up_next         = el_err > el_db;
        down_next       = el_err < -el_db;
        az_pos_next     = az_pos[AZ_POS_W-1:0];
        el_pos_next     = el_ext[EL_POS_W-1:0];
      end
      CMD_WRITE: begin
        if (req_ok) begin
          az_target_next  = sc_az_req;
          el_target_next  = sc_el_req;
          target_set_next = 1'b1;
          accepted_next   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // drive and position outputs double as the held state
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid              <= 1'b0;
      az_target              <= '0;
      el_target              <= '0;
      target_set             <= 1'b0;
      rsp.turn_right         <= 1'b0;
      rsp.turn_left          <= 1'b0;
      rsp.tilt_up            <= 1'b0;
      rsp.tilt_down          <= 1'b0;
      rsp.azimuth_position   <= '0;
      rsp.elevation_position <= '0;
      rsp.command_accepted   <= 1'b0;
    end else begin
      if (sc_ready) begin
        rsp.valid <= sc_valid;
      end
      if (fire) begin
        az_target              <= az_target_next;
        el_target              <= el_target_next;
        target_set             <= target_set_next;
        rsp.turn_right         <= right_next;
        rsp.turn_left          <= left_next;
        rsp.tilt_up            <= up_next;
        rsp.tilt_down          <= down_next;
        rsp.azimuth_position   <= az_pos_next;
        rsp.elevation_position <= el_pos_next;
        rsp.command_accepted   <= accepted_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_fight: assert property (@(posedge clk) disable iff (rst)
    !(rsp.turn_right && rsp.turn_left) && !(rsp.tilt_up && rsp.tilt_down))
    else $error("both directions driven on one axis");

  a_hold_non_tick: assert property (@(posedge clk) disable iff (rst)
    (fire && sc_cmd != CMD_TICK) |=>
      $stable(rsp.turn_right) && $stable(rsp.turn_left) && $stable(rsp.tilt_up) &&
      $stable(rsp.tilt_down) && $stable(rsp.azimuth_position) &&
      $stable(rsp.elevation_position))
    else $error("drive or position changed on a non-tick transaction");

  a_tick_seeds: assert property (@(posedge clk) disable iff (rst)
    (fire && sc_cmd == CMD_TICK) |=> target_set)
    else $error("target not set after a tick");

  a_accept_sets: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.command_accepted) |-> target_set)
    else $error("accepted command without a set target");

  a_accept_only_write: assert property (@(posedge clk) disable iff (rst)
    (fire && sc_cmd != CMD_WRITE) |=> !rsp.command_accepted)
    else $error("command_accepted on a non-write transaction");
`endif

endmodule
